// ===== design/dtfe_pkg.sv =====
package dtfe_pkg;

    // Command codes carried in the mode field
    localparam logic [2:0] MODE_NEXT       = 3'd0;
    localparam logic [2:0] MODE_UP         = 3'd1;
    localparam logic [2:0] MODE_DOWN       = 3'd2;
    localparam logic [2:0] MODE_NAMED_UP   = 3'd3;
    localparam logic [2:0] MODE_NAMED_DOWN = 3'd4;
    localparam logic [2:0] MODE_LOAD       = 3'd5;

    // Field codes, shared by the field input and the cursor
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    // Configuration register indexes
    localparam logic [0:0] CFG_YEAR_FIRST = 1'b0;
    localparam logic [0:0] CFG_YEAR_LAST  = 1'b1;

    localparam logic [13:0] YEAR_FIRST_RST = 14'd2012;
    localparam logic [13:0] YEAR_LAST_RST  = 14'd2049;
    localparam logic [4:0]  HOUR_MAX       = 5'd23;
    localparam logic [5:0]  MINSEC_MAX     = 6'd59;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  field;
        logic [13:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_in_word;

    typedef struct packed {
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [2:0]  cursor_out;
    } t_out_word;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  cursor;
    } t_dt_state;

    // Gregorian leap test; y / 100 by reciprocal multiply (exact below 43699)
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic [13:0] q100;
        logic        div100;
        prod   = 27'(y) * 27'd5243;
        q      = prod[26:19];
        q100   = (14'(q) << 6) + (14'(q) << 5) + (14'(q) << 2);
        div100 = (q100 == y);
        return ((y[1:0] == 2'b00) && !div100) || (div100 && (q[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Step by one and wrap; the low-end test comes first
    function automatic logic [13:0] wrap_step(
        input logic [13:0] val,
        input logic        up,
        input logic [13:0] lo,
        input logic [13:0] hi
    );
        logic signed [15:0] v;
        logic [13:0]        res;
        v = signed'({2'b00, val}) + (up ? 16'sd1 : -16'sd1);
        if (v < signed'({2'b00, lo})) begin
            res = hi;
        end else if (v > signed'({2'b00, hi})) begin
            res = lo;
        end else begin
            res = v[13:0];
        end
        return res;
    endfunction

endpackage

// ===== design/dtfe_next.sv =====
module dtfe_next (
    input  dtfe_pkg::t_dt_state i_state,
    input  dtfe_pkg::t_in_word  i_word,
    input  logic [13:0]         i_year_first,
    input  logic [13:0]         i_year_last,
    output dtfe_pkg::t_dt_state o_state
);

    logic       adj;
    logic       up;
    logic [2:0] sel;
    logic [4:0] len;

    always_comb begin
        o_state = i_state;
        adj     = 1'b0;
        up      = 1'b0;
        sel     = i_state.cursor;
        len     = 5'd31;

        unique case (i_word.mode) inside
            dtfe_pkg::MODE_NEXT: begin
                o_state.cursor = (i_state.cursor >= dtfe_pkg::FLD_SECOND) ?
                                 dtfe_pkg::FLD_YEAR : i_state.cursor + 3'd1;
            end
            dtfe_pkg::MODE_UP: begin
                adj = 1'b1;
                up  = 1'b1;
            end
            dtfe_pkg::MODE_DOWN: begin
                adj = 1'b1;
            end
            dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::MODE_NAMED_DOWN: begin
                if (i_word.field <= dtfe_pkg::FLD_SECOND) begin
                    o_state.cursor = i_word.field;
                    sel            = i_word.field;
                    adj            = 1'b1;
                    up             = (i_word.mode == dtfe_pkg::MODE_NAMED_UP);
                end
            end
            dtfe_pkg::MODE_LOAD: begin
                o_state.year   = i_word.load_year;
                o_state.month  = i_word.load_month;
                o_state.day    = i_word.load_day;
                o_state.hour   = i_word.load_hour;
                o_state.minute = i_word.load_minute;
                o_state.second = i_word.load_second;
                o_state.cursor = dtfe_pkg::FLD_YEAR;
            end
            default: begin
            end
        endcase

        if (adj) begin
            case (sel)
                dtfe_pkg::FLD_YEAR: begin
                    o_state.year = dtfe_pkg::wrap_step(i_state.year, up,
                                                       i_year_first, i_year_last);
                    len = dtfe_pkg::month_len(o_state.year, i_state.month);
                    if (i_state.day > len) begin
                        o_state.day = len;
                    end
                end
                dtfe_pkg::FLD_MONTH: begin
                    o_state.month = 4'(dtfe_pkg::wrap_step(14'(i_state.month), up,
                                                           14'd1, 14'd12));
                    len = dtfe_pkg::month_len(i_state.year, o_state.month);
                    if (i_state.day > len) begin
                        o_state.day = len;
                    end
                end
                dtfe_pkg::FLD_DAY: begin
                    len = dtfe_pkg::month_len(i_state.year, i_state.month);
                    o_state.day = 5'(dtfe_pkg::wrap_step(14'(i_state.day), up,
                                                         14'd1, 14'(len)));
                end
                dtfe_pkg::FLD_HOUR: begin
                    o_state.hour = 5'(dtfe_pkg::wrap_step(14'(i_state.hour), up,
                                      14'd0, 14'(dtfe_pkg::HOUR_MAX)));
                end
                dtfe_pkg::FLD_MINUTE: begin
                    o_state.minute = 6'(dtfe_pkg::wrap_step(14'(i_state.minute), up,
                                        14'd0, 14'(dtfe_pkg::MINSEC_MAX)));
                end
                dtfe_pkg::FLD_SECOND: begin
                    o_state.second = 6'(dtfe_pkg::wrap_step(14'(i_state.second), up,
                                        14'd0, 14'(dtfe_pkg::MINSEC_MAX)));
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/date_time_field_editor_core.sv =====
// A word accepted into the input register moves into the result register when that
// register is empty or drains. Throughput: one word per cycle unless the receiver
// stalls; the date/time state updates as a word moves from the input register into
// the result register, so the next word sees it.
// Reset (synchronous, active low): clears both valids, loads 2012-01-01 00:00:00
// with the cursor on the year, and year bounds 2012..2049.
module date_time_field_editor_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dtfe_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dtfe_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [13:0]          i_cfg_data
);

    logic                r_in_vld;
    dtfe_pkg::t_in_word  r_in;
    logic                r_out_vld;
    dtfe_pkg::t_out_word r_out;
    dtfe_pkg::t_dt_state r_state;
    dtfe_pkg::t_dt_state n_state;
    logic [13:0]         r_year_first;
    logic [13:0]         r_year_last;
    logic                adv;
    logic                in_acc;

    // Advance the held word whenever the result register is empty or drains now
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    // Stall only when a word is held that cannot move on
    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    dtfe_next u_next (
        .i_state      (r_state),
        .i_word       (r_in),
        .i_year_first (r_year_first),
        .i_year_last  (r_year_last),
        .o_state      (n_state)
    );

    // Control, date/time state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_year_first   <= dtfe_pkg::YEAR_FIRST_RST;
            r_year_last    <= dtfe_pkg::YEAR_LAST_RST;
            r_state.year   <= dtfe_pkg::YEAR_FIRST_RST;
            r_state.month  <= 4'd1;
            r_state.day    <= 5'd1;
            r_state.hour   <= 5'd0;
            r_state.minute <= 6'd0;
            r_state.second <= 6'd0;
            r_state.cursor <= dtfe_pkg::FLD_YEAR;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dtfe_pkg::CFG_YEAR_FIRST: r_year_first <= i_cfg_data;
                    dtfe_pkg::CFG_YEAR_LAST:  r_year_last  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_state   <= n_state;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        if (adv) begin
            r_out.year_out   <= n_state.year;
            r_out.month_out  <= n_state.month;
            r_out.day_out    <= n_state.day;
            r_out.hour_out   <= n_state.hour;
            r_out.minute_out <= n_state.minute;
            r_out.second_out <= n_state.second;
            r_out.cursor_out <= n_state.cursor;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cursor <= dtfe_pkg::FLD_SECOND)
        else $error("cursor left the field range");

    a_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in))
        else $error("held input word lost or changed");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced word did not reach the result register");

    a_load_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.mode == dtfe_pkg::MODE_LOAD |=> r_state.cursor == dtfe_pkg::FLD_YEAR)
        else $error("load did not return the cursor to the year");

    a_month_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.mode == dtfe_pkg::MODE_NAMED_UP && r_in.field == dtfe_pkg::FLD_MONTH
        |=> r_state.month >= 4'd1 && r_state.month <= 4'd12)
        else $error("month step left 1..12");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Codes the package leaves unnamed: spare commands and bad field selects
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam logic [2:0] FLD_BAD_6    = 3'd6;
    localparam logic [2:0] FLD_BAD_7    = 3'd7;

    localparam int PHASES         = 6;
    localparam int WORDS_PER_PHASE = 220;
    localparam int DRAIN_CYCLES   = 4;     // margin after the last result
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side

    typedef struct {
        dtfe_pkg::t_in_word  cmd;
        bit                  typed;   // expectation written into the table
        dtfe_pkg::t_out_word want;
    } t_script_row;

    // Stimulus and DUT hookup; every input starts at a known value
    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    dtfe_pkg::t_in_word in_word = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [0:0] cfg_index = dtfe_pkg::CFG_YEAR_FIRST;
    logic [13:0] cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    dtfe_pkg::t_out_word o_out_word;

    // Predicted date/time state and year bounds
    dtfe_pkg::t_dt_state dt;
    logic [13:0] yr_lo_cfg;
    logic [13:0] yr_hi_cfg;

    dtfe_pkg::t_out_word pending_dt_q[$];
    t_script_row         script_q[$];
    dtfe_pkg::t_out_word due_word;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int words_sent     = 0;
    int loads_sent     = 0;
    int words_checked  = 0;
    int quiet_cycles   = 0;

    date_time_field_editor_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in month m of year y; a month outside 1..12 counts as 31 days
    function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
        if (m < 1 || m > 12) return 31;
        if (m == 2) return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // Step by one; test the low end first, then the high end
    function automatic int unsigned bump(input int unsigned v, input bit up,
                                         input int unsigned lo, input int unsigned hi);
        int s;
        s = int'(v) + (up ? 1 : -1);
        if (s < int'(lo)) return hi;
        if (s > int'(hi)) return lo;
        return s;
    endfunction

    // Pull the day back to the month length after a year or month change
    function automatic void trim_day();
        int unsigned len;
        len = days_in(dt.year, dt.month);
        if (dt.day > len) dt.day = 5'(len);
    endfunction

    function automatic void step_field(input logic [2:0] f, input bit up);
        case (f)
            dtfe_pkg::FLD_YEAR: begin
                dt.year = 14'(bump(dt.year, up, yr_lo_cfg, yr_hi_cfg));
                trim_day();
            end
            dtfe_pkg::FLD_MONTH: begin
                dt.month = 4'(bump(dt.month, up, 1, 12));
                trim_day();
            end
            dtfe_pkg::FLD_DAY:
                dt.day    = 5'(bump(dt.day, up, 1, days_in(dt.year, dt.month)));
            dtfe_pkg::FLD_HOUR:
                dt.hour   = 5'(bump(dt.hour, up, 0, dtfe_pkg::HOUR_MAX));
            dtfe_pkg::FLD_MINUTE:
                dt.minute = 6'(bump(dt.minute, up, 0, dtfe_pkg::MINSEC_MAX));
            dtfe_pkg::FLD_SECOND:
                dt.second = 6'(bump(dt.second, up, 0, dtfe_pkg::MINSEC_MAX));
            default: ;
        endcase
    endfunction

    // Apply one command word to the predicted state; return the state after it
    function automatic dtfe_pkg::t_out_word next_date_time(input dtfe_pkg::t_in_word w);
        case (w.mode) inside
            dtfe_pkg::MODE_NEXT:
                dt.cursor = (dt.cursor >= dtfe_pkg::FLD_SECOND) ? dtfe_pkg::FLD_YEAR
                                                                : dt.cursor + 3'd1;
            dtfe_pkg::MODE_UP:   step_field(dt.cursor, 1'b1);
            dtfe_pkg::MODE_DOWN: step_field(dt.cursor, 1'b0);
            dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::MODE_NAMED_DOWN: begin
                if (w.field <= dtfe_pkg::FLD_SECOND) begin
                    dt.cursor = w.field;
                    step_field(w.field, w.mode == dtfe_pkg::MODE_NAMED_UP);
                end
            end
            dtfe_pkg::MODE_LOAD: begin
                dt.year   = w.load_year;
                dt.month  = w.load_month;
                dt.day    = w.load_day;
                dt.hour   = w.load_hour;
                dt.minute = w.load_minute;
                dt.second = w.load_second;
                dt.cursor = dtfe_pkg::FLD_YEAR;
            end
            default: ;
        endcase
        return dtfe_pkg::t_out_word'{dt.year, dt.month, dt.day, dt.hour, dt.minute,
                                     dt.second, dt.cursor};
    endfunction

    // ---------------------------------------------------------------
    // Word builders
    // ---------------------------------------------------------------

    // Command word; fill the load fields with junk, they must be ignored
    function automatic dtfe_pkg::t_in_word cmd_word(input logic [2:0] m, input logic [2:0] f);
        dtfe_pkg::t_in_word w;
        w = dtfe_pkg::t_in_word'($urandom);
        w.mode  = m;
        w.field = f;
        return w;
    endfunction

    function automatic dtfe_pkg::t_in_word load_word(input int y, input int mo, input int d,
                                                     input int h, input int mi, input int s);
        dtfe_pkg::t_in_word w;
        w = cmd_word(dtfe_pkg::MODE_LOAD, 3'($urandom));
        w.load_year   = 14'(y);
        w.load_month  = 4'(mo);
        w.load_day    = 5'(d);
        w.load_hour   = 5'(h);
        w.load_minute = 6'(mi);
        w.load_second = 6'(s);
        return w;
    endfunction

    function automatic dtfe_pkg::t_out_word dt_word(input int y, input int mo, input int d,
                                                    input int h, input int mi, input int s,
                                                    input logic [2:0] c);
        return dtfe_pkg::t_out_word'{14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), c};
    endfunction

    function automatic void add_step(input dtfe_pkg::t_in_word w, input bit typed,
                                     input dtfe_pkg::t_out_word want);
        t_script_row r;
        r.cmd   = w;
        r.typed = typed;
        r.want  = want;
        script_q.push_back(r);
    endfunction

    // Random command: mostly well-formed edits and loads, some noise
    function automatic dtfe_pkg::t_in_word random_word();
        dtfe_pkg::t_in_word w;
        int pick;
        pick = $urandom_range(99);
        w = cmd_word(dtfe_pkg::MODE_NEXT, ($urandom_range(99) < 90) ? 3'($urandom_range(5))
                                                                    : 3'($urandom_range(7)));
        if      (pick < 10) w.mode = dtfe_pkg::MODE_NEXT;
        else if (pick < 30) w.mode = dtfe_pkg::MODE_UP;
        else if (pick < 50) w.mode = dtfe_pkg::MODE_DOWN;
        else if (pick < 65) w.mode = dtfe_pkg::MODE_NAMED_UP;
        else if (pick < 80) w.mode = dtfe_pkg::MODE_NAMED_DOWN;
        else if (pick < 93) w.mode = dtfe_pkg::MODE_LOAD;
        else                w.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
        // Three loads in four carry a sane date, biased to bounds,
        // century years and month ends; the rest keep the raw junk bits
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
                0: w.load_year = 14'($urandom_range(9999));
                1: w.load_year = yr_lo_cfg;
                2: w.load_year = yr_hi_cfg;
                default: w.load_year = 14'($urandom_range(99) * 100);
            endcase
            w.load_month  = 4'($urandom_range(12, 1));
            w.load_day    = $urandom_range(1) ? 5'($urandom_range(31, 28))
                                              : 5'($urandom_range(31, 1));
            w.load_hour   = 5'($urandom_range(dtfe_pkg::HOUR_MAX));
            w.load_minute = 6'($urandom_range(dtfe_pkg::MINSEC_MAX));
            w.load_second = 6'($urandom_range(dtfe_pkg::MINSEC_MAX));
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one word, hold it until taken, then log its expected result.
    // Call and return at a rising edge.
    task automatic put_word(input dtfe_pkg::t_in_word w, input bit typed,
                            input dtfe_pkg::t_out_word want);
        dtfe_pkg::t_out_word predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = next_date_time(w);
        pending_dt_q.push_back(typed ? want : predicted);
        words_sent++;
        if (w.mode == dtfe_pkg::MODE_LOAD) loads_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_dt_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both year bounds on back-to-back edges; hold the enable across them
    task automatic set_year_span(input logic [13:0] lo, input logic [13:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= dtfe_pkg::CFG_YEAR_FIRST;
        cfg_data  <= lo;
        @(posedge i_clk);
        cfg_index <= dtfe_pkg::CFG_YEAR_LAST;
        cfg_data  <= hi;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        yr_lo_cfg = lo;
        yr_hi_cfg = hi;
    endtask

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [13:0] got,
                               input logic [13:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Take each result word on its handshake and compare with the oldest prediction
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (pending_dt_q.size() == 0) begin
                report_mismatch("result word with no command pending");
            end else begin
                due_word = pending_dt_q.pop_front();
                check_field("year",   o_out_word.year_out,   due_word.year_out);
                check_field("month",  o_out_word.month_out,  due_word.month_out);
                check_field("day",    o_out_word.day_out,    due_word.day_out);
                check_field("hour",   o_out_word.hour_out,   due_word.hour_out);
                check_field("minute", o_out_word.minute_out, due_word.minute_out);
                check_field("second", o_out_word.second_out, due_word.second_out);
                check_field("cursor", o_out_word.cursor_out, due_word.cursor_out);
                words_checked++;
            end
        end
    end

    // Watchdog: count cycles in which no word moves on either side
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_dt_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        // Reset state of the predictor: 2012-01-01 00:00:00, cursor on year
        dt        = dtfe_pkg::t_dt_state'{dtfe_pkg::YEAR_FIRST_RST, 4'd1, 5'd1, 5'd0, 6'd0,
                                          6'd0, dtfe_pkg::FLD_YEAR};
        yr_lo_cfg = dtfe_pkg::YEAR_FIRST_RST;
        yr_hi_cfg = dtfe_pkg::YEAR_LAST_RST;

        // Directed script, run against the reset bounds 2012..2049
        add_step(cmd_word(MODE_SPARE_7, dtfe_pkg::FLD_YEAR), 1,
                 dt_word(2012, 1, 1, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(MODE_SPARE_6, FLD_BAD_7), 1,
                 dt_word(2012, 1, 1, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        // year below the low bound wraps to the high bound, and back
        add_step(cmd_word(dtfe_pkg::MODE_DOWN, dtfe_pkg::FLD_MONTH), 1,
                 dt_word(2049, 1, 1, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_UP, dtfe_pkg::FLD_DAY), 1,
                 dt_word(2012, 1, 1, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_MONTH), 1,
                 dt_word(2012, 12, 1, 0, 0, 0, dtfe_pkg::FLD_MONTH));
        // bad field select: nothing moves, cursor included
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_UP, FLD_BAD_6), 1,
                 dt_word(2012, 12, 1, 0, 0, 0, dtfe_pkg::FLD_MONTH));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, FLD_BAD_7), 1,
                 dt_word(2012, 12, 1, 0, 0, 0, dtfe_pkg::FLD_MONTH));
        // every other field wraps low to high
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_DAY), 1,
                 dt_word(2012, 12, 31, 0, 0, 0, dtfe_pkg::FLD_DAY));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_HOUR), 1,
                 dt_word(2012, 12, 31, 23, 0, 0, dtfe_pkg::FLD_HOUR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_MINUTE), 1,
                 dt_word(2012, 12, 31, 23, 59, 0, dtfe_pkg::FLD_MINUTE));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_SECOND), 1,
                 dt_word(2012, 12, 31, 23, 59, 59, dtfe_pkg::FLD_SECOND));
        // cursor wraps from second back to year
        add_step(cmd_word(dtfe_pkg::MODE_NEXT, FLD_BAD_7), 1,
                 dt_word(2012, 12, 31, 23, 59, 59, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::FLD_SECOND), 0, '0);
        // 2000 is leap (divisible by 400): Jan 31 + month clamps to Feb 29
        add_step(load_word(2000, 1, 31, 12, 30, 30), 1,
                 dt_word(2000, 1, 31, 12, 30, 30, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::FLD_MONTH), 0, '0);
        // 1900 is not leap: Mar 31 - month clamps to Feb 28
        add_step(load_word(1900, 3, 31, 0, 0, 0), 1,
                 dt_word(1900, 3, 31, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_MONTH), 0, '0);
        // 2100 not leap: Feb 28 + day wraps to 1
        add_step(load_word(2100, 2, 28, 0, 0, 0), 1,
                 dt_word(2100, 2, 28, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::FLD_DAY), 0, '0);
        // all-ones load, then step the out-of-range month and hour
        add_step(load_word(16383, 15, 31, 31, 63, 63), 1,
                 dt_word(16383, 15, 31, 31, 63, 63, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_MONTH), 0, '0);
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::FLD_HOUR), 0, '0);
        // all-zero load: month 0 counts 31 days, day 0 survives the clamp
        add_step(load_word(0, 0, 0, 0, 0, 0), 1,
                 dt_word(0, 0, 0, 0, 0, 0, dtfe_pkg::FLD_YEAR));
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_DOWN, dtfe_pkg::FLD_YEAR), 0, '0);
        add_step(cmd_word(dtfe_pkg::MODE_NAMED_UP, dtfe_pkg::FLD_DAY), 0, '0);

        // Hold reset, then release it once
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_q[i]) put_word(script_q[i].cmd, script_q[i].typed, script_q[i].want);
        drain();

        // Random phases: change the year bounds while idle, rotate pacing
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: set_year_span(14'd0, 14'd9999);        // widest span
                2: set_year_span(14'd9999, 14'd9999);     // single year at the top
                3: set_year_span(14'd2050, 14'd2020);     // reversed bounds
                4: set_year_span(14'd1999, 14'd2001);     // narrow, around a leap year
                5: begin
                    int lo;
                    lo = $urandom_range(9999);
                    set_year_span(14'(lo), 14'($urandom_range(9999, lo)));
                end
                default: ;                                // keep reset bounds
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) put_word(random_word(), 0, '0);
            drain();
        end

        $display("Run covered %0d command words (%0d loads), %0d result words compared,",
                 words_sent, loads_sent, words_checked);
        $display("over six year-bound settings and four sender/receiver pacing schemes.");
        if (mismatches == 0 && pending_dt_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
